### hdl/mip_chain_layout_unit_assert.svh
// Assertion macros for the mip chain layout unit checkers.
// Both expect signals named clk and rst in the scope where they are used.
`ifndef MIP_CHAIN_LAYOUT_UNIT_ASSERT_SVH
`define MIP_CHAIN_LAYOUT_UNIT_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define MCL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mip chain layout port check failed");

// Consequent must hold in the same cycle as the antecedent.
`define MCL_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mip chain layout port check failed");

`endif

### hdl/mcl_pkg.sv
package mcl_pkg;

  // Field widths
  localparam int DIM_W   = 16;
  localparam int DEPTH_W = 12;
  localparam int LAYER_W = 12;
  localparam int REQ_W   = 5;
  localparam int IDX_W   = 4;
  localparam int OFF_W   = 48;
  localparam int BYTES_W = 5;
  localparam int BLK_W   = 4;

  // Chain limits; OFFSET_ALIGN must be a power of two
  localparam int MAX_LEVELS   = 16;
  localparam int LEVEL_CNT_W  = $clog2(MAX_LEVELS + 1);
  localparam int OFFSET_ALIGN = 16;

  // Input stream packing
  localparam int IN_DATA_W  = 64;
  localparam int IN_W_LSB   = 0;
  localparam int IN_H_LSB   = IN_W_LSB + DIM_W;
  localparam int IN_D_LSB   = IN_H_LSB + DIM_W;
  localparam int IN_L_LSB   = IN_D_LSB + DEPTH_W;
  localparam int IN_REQ_LSB = IN_L_LSB + LAYER_W;

  // Output stream packing
  localparam int OUT_DATA_W = 208;
  localparam int OUT_USER_W = 1;
  localparam int TOTAL_LSB  = IDX_W + OFF_W + 6 * DIM_W + DEPTH_W;

  // Configuration port
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_BLOCK_BYTES  = 2'd0,
    REG_BLOCK_WIDTH  = 2'd1,
    REG_BLOCK_HEIGHT = 2'd2
  } reg_idx_t;

  localparam logic [BYTES_W-1:0] BLOCK_BYTES_RST  = BYTES_W'(4);
  localparam logic [BLK_W-1:0]   BLOCK_WIDTH_RST  = BLK_W'(1);
  localparam logic [BLK_W-1:0]   BLOCK_HEIGHT_RST = BLK_W'(1);

endpackage

### hdl/mip_chain_layout_unit.sv
// Per level: 17-step ceil divide for blocks across, 17 for blocks down (one shared
// radix-2 divider), 6 passes through one shared 49x16 multiplier, align, add, output load.
// A new texture (levels 1..16) is taken only in idle, once the last level of the previous
// one is loaded for output; an output stall holds the emit state.
// Reset (rst, synchronous, active high): idle, no result pending, block_bytes=4,
// block_width=1, block_height=1.
module mip_chain_layout_unit (
  input  logic                              clk,
  input  logic                              rst,
  // APB configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mcl_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [mcl_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [mcl_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  // texture description; low to high: base_width, base_height, base_depth,
  // layer_count, level_request, zero fill
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [mcl_pkg::IN_DATA_W-1:0]     s_tdata,
  // level result; low to high: level_index, level_offset, blocks_across, blocks_down,
  // padded_row_texels, padded_height_texels, level_width, level_height, level_depth,
  // total_bytes
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [mcl_pkg::OUT_DATA_W-1:0]    m_tdata,
  // low to high: size_overflow
  output logic [mcl_pkg::OUT_USER_W-1:0]    m_tuser,
  output logic                              m_tlast
);
  import mcl_pkg::*;

  localparam int NUM_W  = DIM_W + 1;
  localparam int ACC_W  = OFF_W + 1;
  localparam int PROD_W = ACC_W + DIM_W;
  localparam int CNT_W  = $clog2(NUM_W);
  localparam logic [OFF_W-1:0] LIMIT    = {OFF_W{1'b1}};
  localparam logic [ACC_W-1:0] SIZE_SAT = ACC_W'(1) << OFF_W;
  localparam logic [ACC_W-1:0] ALIGN_M  = ACC_W'(OFFSET_ALIGN - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV_X, S_DIV_Y, S_MUL_PRX, S_MUL_PRY, S_MUL_XY,
    S_MUL_L, S_MUL_D, S_MUL_B, S_ALIGN, S_ADD, S_EMIT
  } state_t;

  state_t state;

  // configuration registers
  logic [BYTES_W-1:0] block_bytes;
  logic [BLK_W-1:0]   block_width;
  logic [BLK_W-1:0]   block_height;
  logic [BLK_W-1:0]   bw_eff;
  logic [BLK_W-1:0]   bh_eff;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  // per-item / per-level working registers
  logic [DIM_W-1:0]       lvl_w, lvl_h;
  logic [DEPTH_W-1:0]     lvl_d;
  logic [LAYER_W-1:0]     layers;
  logic [LEVEL_CNT_W-1:0] levels;
  logic [IDX_W-1:0]       lv;
  logic [DIM_W-1:0]       blk_x, blk_y, pad_row, pad_ht;
  logic [ACC_W-1:0]       acc;
  logic [OFF_W-1:0]       off, lvl_off;
  logic                   ovf;

  // shared divider
  logic [NUM_W-1:0] div_n;
  logic [BLK_W-1:0] div_rem;
  logic [CNT_W-1:0] div_cnt;
  logic [BLK_W-1:0] div_dv;
  logic [BLK_W:0]   rem_sh;
  logic             div_ge;
  logic [BLK_W-1:0] rem_new;
  logic [NUM_W-1:0] n_new;

  // shared multiplier
  logic [ACC_W-1:0]  mul_a;
  logic [DIM_W-1:0]  mul_b;
  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0]  prod_sat48;
  logic [DIM_W-1:0]  prod_sat16;

  // input decode
  logic [DIM_W-1:0]       in_w, in_h;
  logic [DEPTH_W-1:0]     in_d;
  logic [REQ_W-1:0]       in_req;
  logic [DIM_W-1:0]       in_max;
  logic [LEVEL_CNT_W-1:0] bit_len;
  logic [REQ_W-1:0]       req_sel;
  logic [LEVEL_CNT_W-1:0] levels_in;

  // offset arithmetic
  logic [ACC_W-1:0] al_sum, al_val;
  logic [OFF_W+1:0] add_sum;
  logic             last;
  logic [DIM_W-1:0] w_half, h_half;
  logic [DEPTH_W-1:0] d_half;

  function automatic logic [DIM_W-1:0] half_one(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v >> 1;
    return (r == '0) ? DIM_W'(1) : r;
  endfunction

  function automatic logic [NUM_W-1:0] ceil_num(input logic [DIM_W-1:0] v,
                                                input logic [BLK_W-1:0] b);
    return {1'b0, v} + NUM_W'(b) - NUM_W'(1);
  endfunction

  // APB register file
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes  <= BLOCK_BYTES_RST;
      block_width  <= BLOCK_WIDTH_RST;
      block_height <= BLOCK_HEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_BLOCK_BYTES:  block_bytes  <= pwdata[BYTES_W-1:0];
        REG_BLOCK_WIDTH:  block_width  <= pwdata[BLK_W-1:0];
        REG_BLOCK_HEIGHT: block_height <= pwdata[BLK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_BLOCK_BYTES:  prdata = APB_DATA_W'(block_bytes);
      REG_BLOCK_WIDTH:  prdata = APB_DATA_W'(block_width);
      REG_BLOCK_HEIGHT: prdata = APB_DATA_W'(block_height);
      default:          prdata = '0;
    endcase
  end

  assign bw_eff = (block_width  == '0) ? BLK_W'(1) : block_width;
  assign bh_eff = (block_height == '0) ? BLK_W'(1) : block_height;

  // input decode and level count
  assign in_w   = (s_tdata[IN_W_LSB +: DIM_W] == '0) ? DIM_W'(1) : s_tdata[IN_W_LSB +: DIM_W];
  assign in_h   = (s_tdata[IN_H_LSB +: DIM_W] == '0) ? DIM_W'(1) : s_tdata[IN_H_LSB +: DIM_W];
  assign in_d   = (s_tdata[IN_D_LSB +: DEPTH_W] == '0) ? DEPTH_W'(1)
                                                       : s_tdata[IN_D_LSB +: DEPTH_W];
  assign in_req = s_tdata[IN_REQ_LSB +: REQ_W];

  always_comb begin
    in_max = (in_w > in_h) ? in_w : in_h;
    if (DIM_W'(in_d) > in_max) in_max = DIM_W'(in_d);
  end

  always_comb begin
    bit_len = '0;
    for (int i = 0; i < DIM_W; i++) begin
      if (in_max[i]) bit_len = LEVEL_CNT_W'(i + 1);
    end
  end

  assign req_sel   = (in_req == '0) ? REQ_W'(bit_len) : in_req;
  assign levels_in = (req_sel > REQ_W'(MAX_LEVELS)) ? LEVEL_CNT_W'(MAX_LEVELS)
                                                    : LEVEL_CNT_W'(req_sel);

  // divider step: one quotient bit per cycle
  assign div_dv  = (state == S_DIV_Y) ? bh_eff : bw_eff;
  assign rem_sh  = {div_rem, div_n[NUM_W-1]};
  assign div_ge  = rem_sh >= {1'b0, div_dv};
  assign rem_new = div_ge ? BLK_W'(rem_sh - {1'b0, div_dv}) : rem_sh[BLK_W-1:0];
  assign n_new   = {div_n[NUM_W-2:0], div_ge};

  // multiplier operand select
  always_comb begin
    case (state)
      S_MUL_PRX: begin mul_a = ACC_W'(blk_x); mul_b = DIM_W'(bw_eff);      end
      S_MUL_PRY: begin mul_a = ACC_W'(blk_y); mul_b = DIM_W'(bh_eff);      end
      S_MUL_XY:  begin mul_a = ACC_W'(blk_x); mul_b = blk_y;               end
      S_MUL_L:   begin mul_a = acc;           mul_b = DIM_W'(layers);      end
      S_MUL_D:   begin mul_a = acc;           mul_b = DIM_W'(lvl_d);       end
      S_MUL_B:   begin mul_a = acc;           mul_b = DIM_W'(block_bytes); end
      default:   begin mul_a = acc;           mul_b = '0;                  end
    endcase
  end

  assign prod       = PROD_W'(mul_a) * PROD_W'(mul_b);
  // anything at or above 2^48 overflows the offset anyway
  assign prod_sat48 = (|prod[PROD_W-1:OFF_W]) ? SIZE_SAT : prod[ACC_W-1:0];
  assign prod_sat16 = (|prod[PROD_W-1:DIM_W]) ? {DIM_W{1'b1}} : prod[DIM_W-1:0];

  // offset alignment and accumulate
  assign al_sum  = {1'b0, off} + ALIGN_M;
  assign al_val  = al_sum & ~ALIGN_M;
  assign add_sum = {2'b00, off} + {1'b0, acc};
  assign last    = ({1'b0, lv} + (IDX_W + 1)'(1)) == (IDX_W + 1)'(levels);

  assign w_half = half_one(lvl_w);
  assign h_half = half_one(lvl_h);
  assign d_half = DEPTH_W'(half_one(DIM_W'(lvl_d)));

  assign s_tready = (state == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // the emit state sets the valid flag itself
      if (m_tvalid && m_tready && state != S_EMIT) m_tvalid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            lvl_w   <= in_w;
            lvl_h   <= in_h;
            lvl_d   <= in_d;
            layers  <= s_tdata[IN_L_LSB +: LAYER_W];
            levels  <= levels_in;
            lv      <= '0;
            off     <= '0;
            ovf     <= 1'b0;
            div_n   <= ceil_num(in_w, bw_eff);
            div_rem <= '0;
            div_cnt <= '0;
            state   <= S_DIV_X;
          end
        end
        S_DIV_X: begin
          if (div_cnt == CNT_W'(NUM_W - 1)) begin
            blk_x   <= n_new[DIM_W-1:0];
            div_n   <= ceil_num(lvl_h, bh_eff);
            div_rem <= '0;
            div_cnt <= '0;
            state   <= S_DIV_Y;
          end else begin
            div_n   <= n_new;
            div_rem <= rem_new;
            div_cnt <= div_cnt + CNT_W'(1);
          end
        end
        S_DIV_Y: begin
          div_n   <= n_new;
          div_rem <= rem_new;
          div_cnt <= div_cnt + CNT_W'(1);
          if (div_cnt == CNT_W'(NUM_W - 1)) begin
            blk_y <= n_new[DIM_W-1:0];
            state <= S_MUL_PRX;
          end
        end
        S_MUL_PRX: begin
          pad_row <= prod_sat16;
          state   <= S_MUL_PRY;
        end
        S_MUL_PRY: begin
          pad_ht <= prod_sat16;
          state  <= S_MUL_XY;
        end
        S_MUL_XY: begin
          acc   <= prod_sat48;
          state <= S_MUL_L;
        end
        S_MUL_L: begin
          acc   <= prod_sat48;
          state <= S_MUL_D;
        end
        S_MUL_D: begin
          acc   <= prod_sat48;
          state <= S_MUL_B;
        end
        S_MUL_B: begin
          acc   <= prod_sat48;
          state <= S_ALIGN;
        end
        S_ALIGN: begin
          if (al_val[OFF_W]) begin
            off     <= LIMIT;
            lvl_off <= LIMIT;
            ovf     <= 1'b1;
          end else begin
            off     <= al_val[OFF_W-1:0];
            lvl_off <= al_val[OFF_W-1:0];
          end
          state <= S_ADD;
        end
        S_ADD: begin
          if (|add_sum[OFF_W+1:OFF_W]) begin
            off <= LIMIT;
            ovf <= 1'b1;
          end else begin
            off <= add_sum[OFF_W-1:0];
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          // load the output register once the previous transfer has gone
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {(last ? off : {OFF_W{1'b0}}), lvl_d, lvl_h, lvl_w,
                         pad_ht, pad_row, blk_y, blk_x, lvl_off, lv};
            m_tuser  <= OUT_USER_W'(ovf);
            m_tlast  <= last;
            m_tvalid <= 1'b1;
            if (last) begin
              state <= S_IDLE;
            end else begin
              lv      <= lv + IDX_W'(1);
              lvl_w   <= w_half;
              lvl_h   <= h_half;
              lvl_d   <= d_half;
              div_n   <= ceil_num(w_half, bw_eff);
              div_rem <= '0;
              div_cnt <= '0;
              state   <= S_DIV_X;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/mcl_port_checker.sv
`include "mip_chain_layout_unit_assert.svh"

module mcl_port_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [mcl_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                           m_tlast
);
  import mcl_pkg::*;

  // stalled result holds
  `MCL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
  // one texture at a time: busy right after an input transfer
  `MCL_ASSERT_NEXT(a_busy_after_in, s_tvalid && s_tready, !s_tready)
  // total only on the last level
  `MCL_ASSERT_SAME(a_total_last_only, m_tvalid && !m_tlast, m_tdata[TOTAL_LSB +: OFF_W] == '0)
  // when idle, only the final level may still be pending
  `MCL_ASSERT_SAME(a_idle_pending_last, s_tready && m_tvalid, m_tlast)

endmodule

bind mip_chain_layout_unit mcl_port_checker u_mcl_port_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

### verif/tb_mip_chain_layout_unit.sv
module tb_mip_chain_layout_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import mcl_pkg::*;

  localparam logic [63:0] FULL48 = (64'd1 << OFF_W) - 64'd1;
  localparam int RAND_PHASES = 5;
  localparam int ITEMS_PER_PHASE = 46;
  localparam int DRAIN_CYCLES = 100;
  localparam int MAX_REPORTS = 40;

  // Texture description, packed exactly as on s_tdata (width in the low bits)
  typedef struct packed {
    logic [REQ_W-1:0]   req;
    logic [LAYER_W-1:0] layers;
    logic [DEPTH_W-1:0] depth;
    logic [DIM_W-1:0]   height;
    logic [DIM_W-1:0]   width;
  } tex_desc_t;

  // One level result: {m_tlast, m_tuser, m_tdata}
  typedef struct packed {
    logic               last;
    logic               ovf;
    logic [OFF_W-1:0]   total;
    logic [DEPTH_W-1:0] depth;
    logic [DIM_W-1:0]   height;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   pad_h;
    logic [DIM_W-1:0]   pad_row;
    logic [DIM_W-1:0]   down;
    logic [DIM_W-1:0]   across;
    logic [OFF_W-1:0]   offset;
    logic [IDX_W-1:0]   index;
  } level_rec_t;

  // Directed row: format, texture, and a hand-written result when last is set
  typedef struct packed {
    logic [BYTES_W-1:0] bytes;
    logic [BLK_W-1:0]   bw;
    logic [BLK_W-1:0]   bh;
    tex_desc_t          desc;
    level_rec_t         want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // width, height, depth, layers, level_request, zero fill

  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // index, offset, across, down, pad_row, pad_h,
                                         // width, height, depth, total_bytes
  logic [OUT_USER_W-1:0] m_tuser;        // size_overflow
  logic                  m_tlast;

  // Shadow of the format registers
  logic [BYTES_W-1:0] fmt_bytes = BLOCK_BYTES_RST;
  logic [BLK_W-1:0]   fmt_bw = BLOCK_WIDTH_RST;
  logic [BLK_W-1:0]   fmt_bh = BLOCK_HEIGHT_RST;

  level_rec_t  levels_due[$];
  plan_row_t   dir_plan[$];
  bit          calm = 1'b0;
  int unsigned hold_left = 0;
  int          mismatches = 0;
  int          textures_sent = 0;
  int          levels_seen = 0;
  int          sat_levels = 0;
  int          formats_used = 1;

  mip_chain_layout_unit i_dut (.*);

  always #10 clk = ~clk;

  // Expected levels of one texture under the current format
  function automatic void layout_chain(input tex_desc_t td);
    logic [63:0] w, h, d, layers, bw, bh, bx, by, size, off, tmp;
    int levels;
    logic ovf;
    level_rec_t r;
    w = (td.width == '0) ? 64'd1 : 64'(td.width);
    h = (td.height == '0) ? 64'd1 : 64'(td.height);
    d = (td.depth == '0) ? 64'd1 : 64'(td.depth);
    layers = 64'(td.layers);
    bw = (fmt_bw == '0) ? 64'd1 : 64'(fmt_bw);
    bh = (fmt_bh == '0) ? 64'd1 : 64'(fmt_bh);
    levels = int'(td.req);
    // full chain: bit length of the largest dimension
    if (levels == 0) begin
      tmp = (w > h) ? w : h;
      if (d > tmp) tmp = d;
      while (tmp != 0) begin
        levels++;
        tmp >>= 1;
      end
    end
    if (levels > MAX_LEVELS) levels = MAX_LEVELS;
    off = '0;
    ovf = 1'b0;
    for (int lv = 0; lv < levels; lv++) begin
      bx = (w + bw - 64'd1) / bw;
      by = (h + bh - 64'd1) / bh;
      size = bx * by * layers * d * 64'(fmt_bytes);
      off = ((off + OFFSET_ALIGN - 1) / OFFSET_ALIGN) * OFFSET_ALIGN;
      if (off > FULL48) begin
        off = FULL48;
        ovf = 1'b1;
      end
      r = '0;
      r.index = IDX_W'(lv);
      r.offset = off[OFF_W-1:0];
      r.across = bx[DIM_W-1:0];
      r.down = by[DIM_W-1:0];
      tmp = bx * bw;
      r.pad_row = (tmp > 64'hFFFF) ? '1 : tmp[DIM_W-1:0];
      tmp = by * bh;
      r.pad_h = (tmp > 64'hFFFF) ? '1 : tmp[DIM_W-1:0];
      r.width = w[DIM_W-1:0];
      r.height = h[DIM_W-1:0];
      r.depth = d[DEPTH_W-1:0];
      // running end saturates at 48 bits
      if (size > FULL48 - off) begin
        off = FULL48;
        ovf = 1'b1;
      end else begin
        off += size;
      end
      r.last = (lv == levels - 1);
      r.total = r.last ? off[OFF_W-1:0] : '0;
      r.ovf = ovf;
      levels_due = {levels_due, r};
      w = (w > 1) ? w >> 1 : 64'd1;
      h = (h > 1) ? h >> 1 : 64'd1;
      d = (d > 1) ? d >> 1 : 64'd1;
    end
  endfunction

  // Append one directed row to the plan
  function automatic void plan_add(input plan_row_t row);
    dir_plan = {dir_plan, row};
  endfunction

  function automatic tex_desc_t tex(input int w, input int h, input int d, input int l,
                                    input int req);
    tex_desc_t td;
    td.width = DIM_W'(w);
    td.height = DIM_W'(h);
    td.depth = DEPTH_W'(d);
    td.layers = LAYER_W'(l);
    td.req = REQ_W'(req);
    return td;
  endfunction

  // Hand-written single-level result: level 0 at offset 0, last of its chain
  function automatic level_rec_t one_level(input logic [DIM_W-1:0] across, down, pad_row,
                                           pad_h, width, height,
                                           input logic [DEPTH_W-1:0] depth,
                                           input logic [OFF_W-1:0] total, input logic ovf);
    level_rec_t r;
    r = '0;
    r.across = across;
    r.down = down;
    r.pad_row = pad_row;
    r.pad_h = pad_h;
    r.width = width;
    r.height = height;
    r.depth = depth;
    r.total = total;
    r.ovf = ovf;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic logic [15:0] rand_field(input int bits);
    logic [15:0] mask;
    mask = 16'((32'd1 << bits) - 1);
    case ($urandom_range(0, 7))
      0: return '0;
      1, 2: return 16'($urandom_range(1, 9));
      3: return 16'(1) << $urandom_range(0, bits - 1);
      4: return mask;
      default: return 16'($urandom) & mask;
    endcase
  endfunction

  function automatic tex_desc_t rand_texture();
    tex_desc_t td;
    td.width = rand_field(DIM_W);
    td.height = rand_field(DIM_W);
    td.depth = DEPTH_W'(rand_field(DEPTH_W));
    if ($urandom_range(0, 1) == 0) td.depth = DEPTH_W'(1);
    td.layers = LAYER_W'(rand_field(LAYER_W));
    case ($urandom_range(0, 3))
      0: td.req = '0;
      1: td.req = REQ_W'($urandom_range(1, MAX_LEVELS));
      default: td.req = REQ_W'($urandom);
    endcase
    return td;
  endfunction

  function automatic void cmp_field(input string what, input logic [63:0] want,
                                    input logic [63:0] got);
    if (got !== want) begin
      if (mismatches < MAX_REPORTS)
        $display("%0t ns: %s expected 0x%0h, actual 0x%0h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_level(input level_rec_t got);
    level_rec_t want;
    if (levels_due.size() == 0) begin
      if (mismatches < MAX_REPORTS)
        $display("%0t ns: level result expected none, actual 0x%0h", $time, got);
      mismatches++;
      return;
    end
    want = levels_due.pop_front();
    levels_seen++;
    if (got.ovf) sat_levels++;
    cmp_field("level_index", want.index, got.index);
    cmp_field("level_offset", want.offset, got.offset);
    cmp_field("blocks_across", want.across, got.across);
    cmp_field("blocks_down", want.down, got.down);
    cmp_field("padded_row_texels", want.pad_row, got.pad_row);
    cmp_field("padded_height_texels", want.pad_h, got.pad_h);
    cmp_field("level_width", want.width, got.width);
    cmp_field("level_height", want.height, got.height);
    cmp_field("level_depth", want.depth, got.depth);
    cmp_field("total_bytes", want.total, got.total);
    cmp_field("size_overflow", want.ovf, got.ovf);
    cmp_field("last_level", want.last, got.last);
  endfunction

  // Result side: check each transfer, stall in random bursts
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_level({m_tlast, m_tuser[0], m_tdata});
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      hold_left <= $urandom_range(0, 6);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Back-to-back writes keep psel high; the caller lowers it
  task automatic reg_write(input reg_idx_t idx, input logic [APB_DATA_W-1:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= APB_ADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_BLOCK_BYTES:  fmt_bytes = val[BYTES_W-1:0];
      REG_BLOCK_WIDTH:  fmt_bw = val[BLK_W-1:0];
      REG_BLOCK_HEIGHT: fmt_bh = val[BLK_W-1:0];
      default: ;
    endcase
  endtask

  // New format, only once every pending level has come out
  task automatic set_format(input logic [BYTES_W-1:0] bytes, input logic [BLK_W-1:0] bw,
                            input logic [BLK_W-1:0] bh);
    s_tvalid <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk);
    reg_write(REG_BLOCK_BYTES, APB_DATA_W'(bytes));
    reg_write(REG_BLOCK_WIDTH, APB_DATA_W'(bw));
    reg_write(REG_BLOCK_HEIGHT, APB_DATA_W'(bh));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    formats_used++;
  endtask

  // One texture transfer; a hand-written result is used when want.last is set
  task automatic send_texture(input tex_desc_t td, input level_rec_t want);
    s_tvalid <= 1'b1;
    s_tdata <= IN_DATA_W'(td);
    do @(posedge clk); while (!s_tready);
    if (want.last) levels_due = {levels_due, want};
    else layout_chain(td);
    textures_sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      s_tdata <= {$urandom, $urandom};
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset format: 4-byte texels, 1x1 blocks
    // smallest texture, one level
    plan_add('{5'd4, 4'd1, 4'd1, tex(1, 1, 1, 1, 1),
               one_level(1, 1, 1, 1, 1, 1, 1, 4, 0)});
    // largest field values: level 0 alone passes 48 bits
    plan_add('{5'd4, 4'd1, 4'd1, tex(65535, 65535, 4095, 4095, 1),
               one_level(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         16'hFFFF, 12'hFFF, OFF_W'(FULL48), 1)});
    // zero dimensions act as 1, zero layers give an empty level
    plan_add('{5'd4, 4'd1, 4'd1, tex(0, 0, 0, 0, 1),
               one_level(1, 1, 1, 1, 1, 1, 1, 0, 0)});
    // full chains of various shapes
    plan_add('{5'd4, 4'd1, 4'd1, tex(32768, 32768, 2048, 2048, 0), '0});
    plan_add('{5'd4, 4'd1, 4'd1, tex(65535, 1, 1, 1, 0), '0});
    plan_add('{5'd4, 4'd1, 4'd1, tex(1, 1, 1, 1, 0),
               one_level(1, 1, 1, 1, 1, 1, 1, 4, 0)});
    plan_add('{5'd4, 4'd1, 4'd1, tex(1, 1, 2048, 1, 0), '0});
    // level requests above the limit are cut
    plan_add('{5'd4, 4'd1, 4'd1, tex(100, 37, 3, 6, 31), '0});
    plan_add('{5'd4, 4'd1, 4'd1, tex(4096, 4096, 1, 2048, 17), '0});
    // level 0 just fits, level 1 pushes the offset over 48 bits
    plan_add('{5'd4, 4'd1, 4'd1, tex(8192, 8192, 1020, 1024, 0), '0});
    // large blocks with partial blocks at the edges
    plan_add('{5'd16, 4'd12, 4'd12, tex(13, 25, 5, 3, 4), '0});
    plan_add('{5'd16, 4'd12, 4'd12, tex(32768, 32768, 1, 1, 1),
               one_level(2731, 2731, 32772, 32772, 32768, 32768, 1,
                         119333776, 0)});
    // zero block sizes act as 1, zero bytes per block give empty levels
    plan_add('{5'd0, 4'd0, 4'd0, tex(7, 9, 1, 1, 1),
               one_level(7, 9, 7, 9, 7, 9, 1, 0, 0)});
    plan_add('{5'd0, 4'd0, 4'd0, tex(50, 50, 2, 3, 3), '0});
    // padded row and height past 16 bits saturate
    plan_add('{5'd31, 4'd13, 4'd11, tex(65535, 65535, 4095, 4095, 0), '0});
    // all-ones registers
    plan_add('{5'd31, 4'd15, 4'd15, tex(65535, 65535, 4095, 4095, 1),
               one_level(4369, 4369, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         12'hFFF, OFF_W'(FULL48), 1)});
    plan_add('{5'd31, 4'd15, 4'd15, tex(1, 65535, 1, 0, 16), '0});
    // single-byte texels
    plan_add('{5'd1, 4'd1, 4'd1, tex(3, 5, 7, 2, 2), '0});
    plan_add('{5'd1, 4'd1, 4'd1, tex(1, 1, 1, 1, 1),
               one_level(1, 1, 1, 1, 1, 1, 1, 1, 0)});

    foreach (dir_plan[i]) begin
      if ({dir_plan[i].bytes, dir_plan[i].bw, dir_plan[i].bh} != {fmt_bytes, fmt_bw, fmt_bh})
        set_format(dir_plan[i].bytes, dir_plan[i].bw, dir_plan[i].bh);
      send_texture(dir_plan[i].desc, dir_plan[i].want);
    end

    // Random textures under several formats; the last phase runs without idling
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        1: set_format(BYTES_W'(1), BLK_W'(12), BLK_W'(1));
        2: set_format(BYTES_W'($urandom), BLK_W'($urandom), BLK_W'($urandom));
        3: set_format(BYTES_W'(16), BLK_W'(1), BLK_W'(12));
        default: set_format(BYTES_W'($urandom_range(1, 16)), BLK_W'($urandom_range(1, 12)),
                            BLK_W'($urandom_range(1, 12)));
      endcase
      if (ph == RAND_PHASES - 1) calm = 1'b1;
      repeat (ITEMS_PER_PHASE) send_texture(rand_texture(), '0);
    end
    s_tvalid <= 1'b0;

    while (levels_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d textures over %0d formats; %0d level results compared.",
             textures_sent, formats_used, levels_seen);
    $display("%0d of those levels had a saturated offset or total.", sat_levels);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Watchdog, several times the slowest expected run
  initial begin
    #40_000_000;
    $display("timeout with %0d level results outstanding", levels_due.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/mcl_pkg.sv
hdl/mip_chain_layout_unit.sv
hdl/mcl_port_checker.sv
verif/tb_mip_chain_layout_unit.sv
